// ===== rtl/core/hsl_to_rgb_converter_macros.svh =====
// Assertion macros for the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define HSL2RGB_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hsl2rgb: invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define HSL2RGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsl2rgb: sequence violated");

`endif

// ===== rtl/core/hsl2rgb_pkg.sv =====
// Types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

	localparam int unsigned FracBits = 12;
	localparam int unsigned UnitW    = FracBits + 1;
	localparam int unsigned HueW     = 9;
	localparam int unsigned ChanW    = 8;
	localparam int unsigned ProdW    = 2 * UnitW;
	localparam int unsigned QW       = 2 * FracBits + 2;
	localparam int unsigned WeightW  = 6;
	localparam int unsigned NumW     = QW + WeightW + 1;
	localparam int unsigned ScaleW   = NumW + 5;
	localparam int unsigned ScaleSh  = 2 * FracBits + 2;

	localparam logic [HueW-1:0] DEG_60  = HueW'(60);
	localparam logic [HueW-1:0] DEG_120 = HueW'(120);
	localparam logic [HueW-1:0] DEG_180 = HueW'(180);
	localparam logic [HueW-1:0] DEG_240 = HueW'(240);
	localparam logic [HueW-1:0] DEG_360 = HueW'(360);

	localparam logic [UnitW-1:0]   UNIT_ONE  = UnitW'(1) << FracBits;
	localparam logic [UnitW-1:0]   UNIT_HALF = UnitW'(1) << (FracBits - 1);
	localparam logic [QW-1:0]      ONE_SQ    = QW'(1) << (2 * FracBits);
	localparam logic [WeightW-1:0] WEIGHT_FULL = WeightW'(60);
	localparam logic [NumW-1:0]    NUM_MAX   = NumW'(60) << (2 * FracBits);
	localparam logic [ChanW-1:0]   CHAN_MAX  = '1;

	typedef struct packed {
		logic [HueW-1:0]  hue_degrees;
		logic [UnitW-1:0] saturation;
		logic [UnitW-1:0] lightness;
	} hsl_pixel_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_pixel_t;

endpackage

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// HSL to RGB converter, five-stage pipeline with valid/ready on both sides.
//
//  channel | dir | handshake            | payload
//  hsl     | in  | hsl_valid/hsl_ready  | hue_degrees, saturation, lightness
//  rgb     | out | rgb_valid/rgb_ready  | red, green, blue
//
// One item per cycle sustained while rgb_ready stays high; five register stages
// (clamp/wrap, l*s product, q/p, ramp multiply, scale by 255/60 and saturate).
// Reset clears only the stage valid bits.
// A stall holds every full stage; empty stages still fill, so bubbles close up.
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter
	import hsl2rgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hsl_valid,
	output logic       hsl_ready,
	input  hsl_pixel_t hsl,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_pixel_t rgb
);

	function automatic logic [HueW-1:0] wrap_deg(input logic [HueW:0] d);
		logic [HueW:0] w;
		w = (d >= {1'b0, DEG_360}) ? d - {1'b0, DEG_360} : d;
		return w[HueW-1:0];
	endfunction

	function automatic logic [WeightW-1:0] ramp_weight(input logic [HueW-1:0] deg);
		logic [HueW-1:0]    fall;
		logic [WeightW-1:0] w;
		fall = DEG_240 - deg;
		if (deg < DEG_60) begin
			w = deg[WeightW-1:0];
		end else if (deg < DEG_180) begin
			w = WEIGHT_FULL;
		end else if (deg < DEG_240) begin
			w = fall[WeightW-1:0];
		end else begin
			w = '0;
		end
		return w;
	endfunction

	function automatic logic [UnitW-1:0] clamp_unit(input logic [UnitW-1:0] v);
		return (v > UNIT_ONE) ? UNIT_ONE : v;
	endfunction

	// floor(num * 255 / (60 * one^2)) == floor(num * 17 / (4 * one^2))
	function automatic logic [ChanW-1:0] scale_chan(input logic [NumW-1:0] num);
		logic [ScaleW-1:0] x17;
		logic [ScaleW-1:0] sh;
		x17 = (ScaleW'(num) << 4) + ScaleW'(num);
		sh  = x17 >> ScaleSh;
		return (sh > ScaleW'(CHAN_MAX)) ? CHAN_MAX : sh[ChanW-1:0];
	endfunction

	function automatic logic [NumW-1:0] ramp_num(input logic [QW-1:0] lo,
			input logic [QW-1:0] diff, input logic [WeightW-1:0] w);
		return NumW'(lo) * NumW'(WEIGHT_FULL) + NumW'(diff) * NumW'(w);
	endfunction

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign rdy5      = !v_s5 || rgb_ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign hsl_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= hsl_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: clamp, hue wrap, per-channel angles
	logic [HueW-1:0]  hue_w;
	logic [HueW-1:0]  deg_r_s1, deg_g_s1, deg_b_s1;
	logic [UnitW-1:0] sat_s1, lit_s1;

	assign hue_w = wrap_deg({1'b0, hsl.hue_degrees});

	always_ff @(posedge clk) begin
		if (rdy1) begin
			deg_g_s1 <= hue_w;
			deg_r_s1 <= wrap_deg({1'b0, hue_w} + {1'b0, DEG_120});
			deg_b_s1 <= wrap_deg({1'b0, hue_w} + {1'b0, DEG_240});
			sat_s1   <= clamp_unit(hsl.saturation);
			lit_s1   <= clamp_unit(hsl.lightness);
		end
	end

	// stage 2: l*s product, ramp weights
	logic [ProdW-1:0]   prod_s2;
	logic [UnitW-1:0]   sat_s2, lit_s2;
	logic [WeightW-1:0] w_r_s2, w_g_s2, w_b_s2;
	logic               gray_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			prod_s2 <= ProdW'(lit_s1) * ProdW'(sat_s1);
			sat_s2  <= sat_s1;
			lit_s2  <= lit_s1;
			gray_s2 <= (sat_s1 == '0);
			w_r_s2  <= ramp_weight(deg_r_s1);
			w_g_s2  <= ramp_weight(deg_g_s1);
			w_b_s2  <= ramp_weight(deg_b_s1);
		end
	end

	// stage 3: q and p with 2*FracBits fraction bits, gray level
	logic [QW-1:0]        l_sq, s_sq, hi, lo;
	logic [UnitW+7:0]     gray_full;
	logic [QW-1:0]        lo_s3, diff_s3;
	logic [WeightW-1:0]   w_r_s3, w_g_s3, w_b_s3;
	logic                 gray_s3;
	logic [ChanW-1:0]     gray_val_s3;
	logic [UnitW+7:FracBits] gray_lvl;

	assign l_sq = QW'(lit_s2) << FracBits;
	assign s_sq = QW'(sat_s2) << FracBits;
	assign hi   = (lit_s2 < UNIT_HALF) ? l_sq + QW'(prod_s2)
	                                   : l_sq + s_sq - QW'(prod_s2);
	assign lo   = (l_sq << 1) - hi;
	assign gray_full = {lit_s2, 8'b0} - (UnitW+8)'(lit_s2);
	assign gray_lvl  = gray_full[UnitW+7:FracBits];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			lo_s3       <= lo;
			diff_s3     <= hi - lo;
			w_r_s3      <= w_r_s2;
			w_g_s3      <= w_g_s2;
			w_b_s3      <= w_b_s2;
			gray_s3     <= gray_s2;
			gray_val_s3 <= (gray_lvl > ($bits(gray_lvl))'(CHAN_MAX)) ? CHAN_MAX
			               : gray_lvl[FracBits+ChanW-1:FracBits];
		end
	end

	// stage 4: ramp numerators, p*60 + (q-p)*weight
	logic [NumW-1:0]  num_r_s4, num_g_s4, num_b_s4;
	logic             gray_s4;
	logic [ChanW-1:0] gray_val_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			num_r_s4    <= ramp_num(lo_s3, diff_s3, w_r_s3);
			num_g_s4    <= ramp_num(lo_s3, diff_s3, w_g_s3);
			num_b_s4    <= ramp_num(lo_s3, diff_s3, w_b_s3);
			gray_s4     <= gray_s3;
			gray_val_s4 <= gray_val_s3;
		end
	end

	// stage 5: scale, saturate, output register
	rgb_pixel_t rgb_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			if (gray_s4) begin
				rgb_s5.red   <= gray_val_s4;
				rgb_s5.green <= gray_val_s4;
				rgb_s5.blue  <= gray_val_s4;
			end else begin
				rgb_s5.red   <= scale_chan(num_r_s4);
				rgb_s5.green <= scale_chan(num_g_s4);
				rgb_s5.blue  <= scale_chan(num_b_s4);
			end
		end
	end

	assign rgb_valid = v_s5;
	assign rgb       = rgb_s5;

	logic num_in_range;

	assign num_in_range = (num_r_s4 <= NUM_MAX) && (num_g_s4 <= NUM_MAX)
	                      && (num_b_s4 <= NUM_MAX);

	// q never exceeds 1.0
	`HSL2RGB_ASSERT_ALWAYS(a_q_le_one, !v_s3 || ((lo_s3 + diff_s3) <= ONE_SQ))
	// ramp numerators stay within 60 * 1.0
	`HSL2RGB_ASSERT_ALWAYS(a_num_range, !v_s4 || num_in_range)
	`HSL2RGB_ASSERT_NEXT(a_advance, v_s4 && rdy5, rgb_valid)
	`HSL2RGB_ASSERT_NEXT(a_gray_out, v_s4 && rdy5 && gray_s4, rgb.red == rgb.green && rgb.green == rgb.blue)

endmodule
